@@ hdl/greedy_word_wrap_justify_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the word wrap block
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_JUSTIFY_ASSERT_SVH
`define GREEDY_WORD_WRAP_JUSTIFY_ASSERT_SVH

// condition must never hold outside reset
`define GWWJ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

// condition must hold in the cycle after a reset cycle
`define GWWJ_ASSERT_AFTER_RST(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) !rst_n |=> (expr)) \
        else $error("wrong state after reset");

`endif

@@ hdl/gwwj_pkg.sv @@
// ---------------------------------------------------------------------------
// gwwj_pkg
// Types, codes and helpers shared by the word wrap modules.
// ---------------------------------------------------------------------------
package gwwj_pkg;

    localparam int MAX_LINE_WORDS_DEF = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_IDX_W          = 3;

    typedef enum logic [1:0] {
        CMD_GLYPH   = 2'd0,
        CMD_ALIGN   = 2'd1,
        CMD_NEWLINE = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_RIGHT  = 2'd1,
        ALIGN_CENTER = 2'd2,
        ALIGN_BLOCK  = 2'd3
    } t_align;

    typedef enum logic {
        KIND_GLYPH = 1'b0,
        KIND_WORD  = 1'b1
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_ADV = 3'd4;

    typedef struct packed {
        t_cmd               cmd;
        logic [14:0]        adv;
        logic signed [14:0] kern;
        logic               last;
        t_align             align;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        word_number;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } t_cfg_wr;

    localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

    // clamp a wide signed sum to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/gwwj_front.sv @@
// ---------------------------------------------------------------------------
// gwwj_front
// Input stage: take words from the stream, decode the command, queue them.
// ---------------------------------------------------------------------------
module gwwj_front
    import gwwj_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [31:0] i_tdata,
    input  logic [1:0]  i_tuser,
    input  logic        i_tlast,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_tready = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    // drop fields the command does not use
    always_comb begin
        n_item       = '0;
        n_item.cmd   = t_cmd'(i_tuser);
        case (n_item.cmd)
            CMD_GLYPH: begin
                n_item.adv  = i_tdata[14:0];
                n_item.kern = i_tdata[29:15];
                n_item.last = i_tlast;
            end
            CMD_ALIGN: begin
                n_item.align = t_align'(i_tdata[31:30]);
            end
            default: begin
                n_item.last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
        if (i_tvalid && o_tready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/gwwj_fifo.sv @@
// ---------------------------------------------------------------------------
// gwwj_fifo
// Short queue of decoded items between the front and back stages.
// ---------------------------------------------------------------------------
module gwwj_fifo
    import gwwj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/gwwj_back.sv @@
// ---------------------------------------------------------------------------
// gwwj_back
// Execution stage: word widths, line packing, line close and placement.
// ---------------------------------------------------------------------------
module gwwj_back
    import gwwj_pkg::*;
#(
    parameter int MAX_LINE_WORDS = MAX_LINE_WORDS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_last,
    input  logic    i_ready
);

    localparam int CW = $clog2(MAX_LINE_WORDS + 1);
    localparam int AW = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam int NW = 33;
    localparam int DW = $clog2(NW + 1);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_KADD  = 15'b000000000000010,
        S_GOUT  = 15'b000000000000100,
        S_AADD  = 15'b000000000001000,
        S_FIN   = 15'b000000000010000,
        S_FIN2  = 15'b000000000100000,
        S_CST   = 15'b000000001000000,
        S_DIV   = 15'b000000010000000,
        S_DFIX  = 15'b000000100000000,
        S_RD    = 15'b000001000000000,
        S_EMIT  = 15'b000010000000000,
        S_CDONE = 15'b000100000000000,
        S_CLR   = 15'b001000000000000,
        S_END   = 15'b010000000000000,
        S_SPARE = 15'b100000000000000
    } t_state;

    // configuration
    logic signed [31:0] r_org_x, r_org_y;
    logic [15:0]        r_font;
    logic [30:0]        r_max;
    logic [14:0]        r_sadv;

    // text state
    t_state             r_st, n_st, r_ret, n_ret;
    logic signed [31:0] r_ww, n_ww, r_ll, n_ll, r_pen, n_pen;
    logic [CW-1:0]      r_cnt, n_cnt;
    t_align             r_align, n_align;
    logic [15:0]        r_wc, n_wc;
    logic               r_open, n_open;
    t_item              r_item, n_item;

    // arithmetic
    logic signed [32:0] r_prod, n_prod;
    logic [30:0]        r_sprod;
    logic signed [31:0] r_fin_ll, n_fin_ll;
    logic signed [31:0] r_x, n_x, r_sp, n_sp;
    logic [15:0]        r_first, n_first;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_neg, n_neg;
    logic [NW-1:0]      r_num, n_num;
    logic [CW-1:0]      r_rem, n_rem;
    logic [DW-1:0]      r_dcnt, n_dcnt;

    // line word widths
    logic signed [31:0] r_mem [MAX_LINE_WORDS];
    logic signed [31:0] r_memq;

    // result staging
    logic               r_pend_v, n_pend_v, r_out_v, n_out_v, r_out_last, n_out_last;
    t_result            r_pend, n_pend, r_out, n_out;
    logic               w_can_emit;

    logic signed [35:0] w_scaled, w_space, w_ww, w_ll, w_max, w_font, w_slack;
    logic signed [35:0] w_sum, w_q;
    logic [CW:0]        w_rem2;
    logic [CW-1:0]      w_div;
    logic [CW-1:0]      w_cnt_inc;

    assign w_scaled  = 36'(r_prod >>> 14);
    assign w_space   = $signed({19'b0, r_sprod[30:14]});
    assign w_ww      = 36'(r_ww);
    assign w_ll      = 36'(r_ll);
    assign w_max     = $signed({5'b0, r_max});
    assign w_font    = $signed({20'b0, r_font});
    assign w_slack   = w_max - w_ll;
    assign w_sum     = w_ll + w_space + w_ww;
    assign w_div     = r_cnt - 1'b1;
    assign w_rem2    = {r_rem, r_num[NW-1]};
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_q       = r_neg ? -($signed({3'b0, r_num}) + 36'(r_rem != '0))
                             : $signed({3'b0, r_num});

    assign w_can_emit = !r_pend_v || !r_out_v || i_ready;
    assign o_pop      = (r_st == S_IDLE) && i_valid;
    assign o_valid    = r_out_v;
    assign o_result   = r_out;
    assign o_last     = r_out_last;

    always_comb begin
        n_st     = r_st;     n_ret   = r_ret;    n_ww     = r_ww;   n_ll  = r_ll;
        n_pen    = r_pen;    n_cnt   = r_cnt;    n_align  = r_align;
        n_wc     = r_wc;     n_open  = r_open;   n_item   = r_item; n_prod = r_prod;
        n_fin_ll = r_fin_ll; n_x     = r_x;      n_sp     = r_sp;   n_first = r_first;
        n_idx    = r_idx;    n_neg   = r_neg;    n_num    = r_num;  n_rem = r_rem;
        n_dcnt   = r_dcnt;   n_pend  = r_pend;   n_pend_v = r_pend_v;
        n_out    = r_out;    n_out_last = r_out_last;
        n_out_v  = r_out_v && !i_ready;

        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    n_prod = $signed({1'b0, r_font}) * 33'(i_item.kern);
                    case (i_item.cmd)
                        CMD_GLYPH: begin
                            n_open = 1'b1;
                            n_st   = S_KADD;
                        end
                        CMD_ALIGN: begin
                            n_open  = 1'b1;
                            n_align = i_item.align;
                            n_st    = S_END;
                        end
                        CMD_NEWLINE: begin
                            n_open = 1'b1;
                            n_ret  = S_END;
                            n_st   = S_CST;
                        end
                        default: begin
                            n_ret = S_CLR;
                            n_st  = S_CST;
                        end
                    endcase
                end
            end
            S_KADD: begin
                if (r_ww != '0) begin
                    n_ww = sat32(w_ww + w_scaled);
                end
                n_prod = $signed({1'b0, r_font}) * $signed({18'b0, r_item.adv});
                n_st   = S_GOUT;
            end
            S_GOUT: begin
                if (w_can_emit) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1; n_out = r_pend; n_out_last = 1'b0;
                    end
                    n_pend_v           = 1'b1;
                    n_pend.kind        = KIND_GLYPH;
                    n_pend.word_number = r_wc;
                    n_pend.pos_x       = r_ww;
                    n_pend.pos_y       = '0;
                    n_st               = S_AADD;
                end
            end
            S_AADD: begin
                n_ww = sat32(w_ww + w_scaled);
                n_st = r_item.last ? S_FIN : S_END;
            end
            S_FIN: begin
                // pack greedily; a word that does not fit closes the line first
                if (r_cnt == '0) begin
                    n_fin_ll = r_ww;
                    n_st     = S_FIN2;
                end else if (w_sum < w_max) begin
                    n_fin_ll = sat32(w_sum);
                    n_st     = S_FIN2;
                end else begin
                    n_fin_ll = r_ww;
                    n_ret    = S_FIN2;
                    n_st     = S_CST;
                end
            end
            S_FIN2: begin
                n_cnt = w_cnt_inc;
                n_wc  = r_wc + 1'b1;
                n_ww  = '0;
                n_ll  = r_fin_ll;
                if (w_cnt_inc >= CW'(MAX_LINE_WORDS)) begin
                    n_ret = S_END;
                    n_st  = S_CST;
                end else begin
                    n_st = S_END;
                end
            end
            S_CST: begin
                if (r_cnt == '0) begin
                    n_pen = sat32(36'(r_pen) - w_font);
                    n_st  = r_ret;
                end else begin
                    n_sp    = sat32(w_space);
                    n_first = r_wc - 16'(r_cnt);
                    n_idx   = '0;
                    case (r_align)
                        ALIGN_RIGHT:  n_x = sat32(w_slack);
                        ALIGN_CENTER: n_x = sat32(w_slack >>> 1);
                        default:      n_x = r_org_x;
                    endcase
                    if (r_align == ALIGN_BLOCK && r_cnt > CW'(1)) begin
                        n_neg  = w_slack < 0;
                        n_num  = (w_slack < 0) ? NW'(-w_slack) : NW'(w_slack);
                        n_rem  = '0;
                        n_dcnt = DW'(NW);
                        n_st   = S_DIV;
                    end else begin
                        n_st = S_RD;
                    end
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                if (w_rem2 >= {1'b0, w_div}) begin
                    n_rem = CW'(w_rem2 - {1'b0, w_div});
                    n_num = {r_num[NW-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2[CW-1:0];
                    n_num = {r_num[NW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == DW'(1)) begin
                    n_st = S_DFIX;
                end
            end
            S_DFIX: begin
                n_sp = sat32(w_space + w_q);
                n_st = S_RD;
            end
            S_RD: begin
                n_st = S_EMIT;
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1; n_out = r_pend; n_out_last = 1'b0;
                    end
                    n_pend_v           = 1'b1;
                    n_pend.kind        = KIND_WORD;
                    n_pend.word_number = r_first + 16'(r_idx);
                    n_pend.pos_x       = r_x;
                    n_pend.pos_y       = r_pen;
                    n_x                = sat32(36'(r_x) + 36'(r_memq) + 36'(r_sp));
                    n_idx              = r_idx + 1'b1;
                    n_st               = (n_idx == r_cnt) ? S_CDONE : S_RD;
                end
            end
            S_CDONE: begin
                n_cnt = '0;
                n_ll  = '0;
                n_pen = sat32(36'(r_pen) - w_font);
                n_st  = r_ret;
            end
            S_CLR: begin
                n_ww    = '0;
                n_ll    = '0;
                n_cnt   = '0;
                n_pen   = r_org_y;
                n_align = ALIGN_LEFT;
                n_wc    = '0;
                n_open  = 1'b0;
                n_st    = S_END;
            end
            S_END: begin
                // release the held result as the last of this run
                if (!r_pend_v) begin
                    n_st = S_IDLE;
                end else if (!r_out_v || i_ready) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_st       = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        if (i_cfg.we && i_cfg.idx == REG_ORIGIN_Y && !r_open) begin
            n_pen = $signed(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ret    <= S_END;
            r_ww     <= '0;
            r_ll     <= '0;
            r_pen    <= '0;
            r_cnt    <= '0;
            r_align  <= ALIGN_LEFT;
            r_wc     <= '0;
            r_open   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_font   <= 16'd4096;
            r_max    <= '0;
            r_sadv   <= 15'd4096;
        end else begin
            r_st     <= n_st;
            r_ret    <= n_ret;
            r_ww     <= n_ww;
            r_ll     <= n_ll;
            r_pen    <= n_pen;
            r_cnt    <= n_cnt;
            r_align  <= n_align;
            r_wc     <= n_wc;
            r_open   <= n_open;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_ORIGIN_X:  r_org_x <= $signed(i_cfg.data);
                    REG_ORIGIN_Y:  r_org_y <= $signed(i_cfg.data);
                    REG_FONT_SIZE: r_font  <= i_cfg.data[15:0];
                    REG_MAX_LINE:  r_max   <= i_cfg.data[30:0];
                    REG_SPACE_ADV: r_sadv  <= i_cfg.data[14:0];
                    default: ;
                endcase
            end
        end
        r_item     <= n_item;
        r_prod     <= n_prod;
        r_sprod    <= {15'b0, r_font} * {16'b0, r_sadv};
        r_fin_ll   <= n_fin_ll;
        r_x        <= n_x;
        r_sp       <= n_sp;
        r_first    <= n_first;
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_memq     <= r_mem[r_idx[AW-1:0]];
        if (r_st == S_FIN2) begin
            r_mem[r_cnt[AW-1:0]] <= r_ww;
        end
    end

endmodule

@@ hdl/greedy_word_wrap_justify.sv @@
// ---------------------------------------------------------------------------
// greedy_word_wrap_justify
// Greedy line breaking of glyph words with left/right/center/block placement.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command word per transfer: tuser is the command
//   (glyph, set alignment, new line, end of text), tdata the glyph advance,
//   kerning and alignment, tlast marks the last glyph of a word.
//   Master stream returns glyph offsets (tuser low) and word placements
//   (tuser high); tlast marks the final result caused by one command.
//   Configuration is a plain write port, used only while the block is idle.
// Execution:
//   A glyph passes the input register and the queue, then the execute states
//   KADD, GOUT, AADD and END; a glyph that ends a word also passes FIN and FIN2.
//   A line close runs CST, then RD and EMIT for each word on the line, then
//   CDONE; an empty line needs only CST. Block alignment adds a bit-serial
//   divider that spreads the slack. The execute state machine sets the rate.
// Reset and stall:
//   Synchronous active-low reset restores register defaults and empties the
//   queue. A stalled receiver holds the output register; one more result is
//   kept in a staging register, then execution waits while the front still
//   fills the queue.
// ---------------------------------------------------------------------------
`include "greedy_word_wrap_justify_assert.svh"

module greedy_word_wrap_justify
    import gwwj_pkg::*;
#(
    parameter int MAX_LINE_WORDS = MAX_LINE_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // glyph_advance, glyph_kerning, alignment
    input  logic [1:0]           s_axis_tuser,  // command
    input  logic                 s_axis_tlast,  // word_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [79:0]          m_axis_tdata,  // word_number, pos_x, pos_y
    output logic                 m_axis_tuser,  // kind
    output logic                 m_axis_tlast   // run_last
);

    t_cfg_wr w_cfg;
    logic    w_fe_valid, w_q_ready, w_q_valid, w_q_pop;
    t_item   w_fe_item, w_q_item;
    t_result w_res;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // decode and register incoming words
    gwwj_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .o_valid  (w_fe_valid),
        .o_item   (w_fe_item),
        .i_ready  (w_q_ready)
    );

    // decouple front from execution
    gwwj_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_valid),
        .i_item  (w_fe_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // word widths, packing and line placement
    gwwj_back #(
        .MAX_LINE_WORDS (MAX_LINE_WORDS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_q_pop),
        .o_valid  (m_axis_tvalid),
        .o_result (w_res),
        .o_last   (m_axis_tlast),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tdata = {w_res.pos_y, w_res.pos_x, w_res.word_number};

    `GWWJ_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_q_pop && !w_q_valid)
    `GWWJ_ASSERT_AFTER_RST(a_out_idle, i_clk, i_rst_n, !m_axis_tvalid)
    `GWWJ_ASSERT_AFTER_RST(a_queue_empty, i_clk, i_rst_n, !w_q_valid && !w_fe_valid)

endmodule
